[rtl/bdlp_pkg.sv]
// ---------------------------------------------------------------------------
// bdlp_pkg: shared types and constants
// Button count, event codes, register indexes and the event slot that
// travels along the cell chain.
// ---------------------------------------------------------------------------
package bdlp_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int IDX_W       = $clog2(NUM_BUTTONS);
  localparam int LEVEL_W     = 16;
  localparam int TICKS_W     = 16;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int KIND_W      = 2;
  localparam int OUT_DATA_W  = 8;
  localparam int SLOT_CNT    = 2 * NUM_BUTTONS;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2
  } ev_kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_MASK     = 2'd2,
    REG_IN_USE   = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // one event slot
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    ev_kind_t         kind;
  } evt_t;

  // control shared by all cells
  typedef struct packed {
    logic               tick;
    logic               shift;
    logic [TICKS_W-1:0] deb_ticks;
    logic [TICKS_W-1:0] long_ticks;
  } cell_ctl_t;

endpackage

[rtl/button_debounce_long_press_unit.sv]
// ---------------------------------------------------------------------------
// button_debounce_long_press_unit: debouncer with long-press events
// Sixteen button cells in a row; a tick updates the cells in use and the events
// they raise are shifted out through cell zero into an output register.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one request per tick, in_tdata holds the raw pin levels.
//   out_*  : one request per event, ascending button order, long press
//            before press/release of the same button; out_tlast marks the
//            final event of the tick. A tick with no event gives nothing.
//   cfg_*  : register writes; the user must make them only while idle,
//            the unit itself does not enforce this.
// Flow:
//   an accepted tick starts a scan in which the chain of 32 slots shifts
//   once per cycle while the head slot is empty or the output register is
//   free; a new tick is taken only once all slots are empty.
// Reset:
//   rst_n clears all button state, loads the register defaults and leaves
//   the unit idle with no pending event.
// Stall:
//   while the output register is full and out_tready is low the chain holds
//   at a valid head slot; the last event of a tick may wait in the output
//   register while the next tick is accepted.
// ---------------------------------------------------------------------------
module button_debounce_long_press_unit
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tick request
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [LEVEL_W-1:0]    in_tdata,   // [15:0] pin_levels
  // event request
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] button_index, [5:4] event_kind
  output logic                  out_tlast,  // last_event
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [TICKS_W-1:0]   deb_ticks_r;
  logic [TICKS_W-1:0]   long_ticks_r;
  logic [LEVEL_W-1:0]   mask_r;
  logic [COUNT_W-1:0]   in_use_r;
  logic                 out_valid_r, out_valid_nxt;
  evt_t                 out_evt_r, out_evt_nxt;
  logic                 out_last_r, out_last_nxt;

  evt_t                 slot_a [NUM_BUTTONS];
  evt_t                 slot_b [NUM_BUTTONS];
  evt_t                 chain_in [NUM_BUTTONS];
  logic [SLOT_CNT-1:0]  slot_valid;
  cell_ctl_t            ctl;
  logic                 in_acc;
  logic                 out_free;
  logic                 head_valid;
  logic                 any_valid;
  logic                 rest_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= TICKS_W'(20);
      long_ticks_r <= TICKS_W'(1000);
      mask_r       <= '1;
      in_use_r     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: deb_ticks_r  <= cfg_wdata[TICKS_W-1:0];
        REG_LONG:     long_ticks_r <= cfg_wdata[TICKS_W-1:0];
        REG_MASK:     mask_r       <= cfg_wdata[LEVEL_W-1:0];
        REG_IN_USE:   in_use_r     <= cfg_wdata[COUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign head_valid = slot_a[0].valid;
  assign any_valid  = |slot_valid;
  assign rest_valid = |slot_valid[SLOT_CNT-1:1];

  // shared cell control
  always_comb begin
    ctl.tick       = in_acc;
    ctl.shift      = (state_r == ST_SCAN) && (!head_valid || out_free);
    ctl.deb_ticks  = deb_ticks_r;
    ctl.long_ticks = long_ticks_r;
  end

  // row of button cells
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_cell
    if (i == NUM_BUTTONS - 1) begin : g_end
      assign chain_in[i] = '0;
    end else begin : g_mid
      assign chain_in[i] = slot_a[i+1];
    end

    bdlp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .idx    (IDX_W'(i)),
      .en     (COUNT_W'(i) < in_use_r),
      .level  (in_tdata[i]),
      .pol    (mask_r[i]),
      .nxt_a  (chain_in[i]),
      .slot_a (slot_a[i]),
      .slot_b (slot_b[i])
    );

    assign slot_valid[2*i]   = slot_a[i].valid;
    assign slot_valid[2*i+1] = slot_b[i].valid;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (!any_valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_evt_nxt   = out_evt_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_SCAN) && head_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_evt_nxt   = slot_a[0];
      out_last_nxt  = !rest_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_evt_r  <= out_evt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_evt_r.kind, out_evt_r.idx});
  assign out_tlast  = out_last_r;

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !any_valid)
    else $error("event slots pending while idle");

  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("tick accepted without scan");

  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_evt_r.kind == EV_PRESS || out_evt_r.kind == EV_RELEASE ||
                    out_evt_r.kind == EV_LONG))
    else $error("bad event kind");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && head_valid && !out_free) |=> head_valid)
    else $error("head event lost under stall");

endmodule

[rtl/bdlp_cell.sv]
// ---------------------------------------------------------------------------
// bdlp_cell: state of one button
// Holds the debounce and long-press countdowns of one button, updates them
// on a tick and loads up to two events into its slots; the slots then shift
// toward cell zero one place per cycle whenever the shift control is set.
// ---------------------------------------------------------------------------
module bdlp_cell
  import bdlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic             en,
  input  logic             level,
  input  logic             pol,
  input  evt_t             nxt_a,
  output evt_t             slot_a,
  output evt_t             slot_b
);

  logic               prev_r, prev_nxt;
  logic [TICKS_W-1:0] deb_rem_r, deb_rem_nxt;
  logic               deb_run_r, deb_run_nxt;
  logic               pf_r, pf_nxt;
  logic [TICKS_W-1:0] long_rem_r, long_rem_nxt;
  logic               long_run_r, long_run_nxt;
  evt_t               a_r, a_nxt;
  evt_t               b_r, b_nxt;

  logic long_exp;
  logic deb_exp;
  logic btn_down;

  assign long_exp   = long_run_r && (long_rem_r <= TICKS_W'(1));
  assign deb_exp    = deb_run_r && (deb_rem_r <= TICKS_W'(1));
  assign btn_down   = pol ? !level : level;

  // per-tick update of the button state, slot shift between ticks
  always_comb begin
    prev_nxt     = prev_r;
    deb_rem_nxt  = deb_rem_r;
    deb_run_nxt  = deb_run_r;
    pf_nxt       = pf_r;
    long_rem_nxt = long_rem_r;
    long_run_nxt = long_run_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    if (ctl.tick) begin
      a_nxt = '{valid: 1'b0, idx: idx, kind: EV_LONG};
      b_nxt = '{valid: 1'b0, idx: idx, kind: EV_PRESS};
      if (en) begin
        // long-press countdown comes first
        if (long_run_r) begin
          if (long_exp) begin
            long_rem_nxt = '0;
            long_run_nxt = 1'b0;
            a_nxt.valid  = pf_r;
          end else begin
            long_rem_nxt = long_rem_r - TICKS_W'(1);
          end
        end
        // debounce outcome
        if (level != prev_r) begin
          prev_nxt    = level;
          deb_rem_nxt = ctl.deb_ticks;
          deb_run_nxt = 1'b1;
        end else if (deb_exp) begin
          deb_rem_nxt = '0;
          deb_run_nxt = 1'b0;
          if (btn_down && !pf_r) begin
            pf_nxt       = 1'b1;
            long_rem_nxt = ctl.long_ticks;
            long_run_nxt = 1'b1;
            b_nxt.valid  = 1'b1;
            b_nxt.kind   = EV_PRESS;
          end else if (!btn_down && pf_r) begin
            pf_nxt       = 1'b0;
            long_rem_nxt = '0;
            long_run_nxt = 1'b0;
            b_nxt.valid  = 1'b1;
            b_nxt.kind   = EV_RELEASE;
          end
        end else if (deb_run_r) begin
          deb_rem_nxt = deb_rem_r - TICKS_W'(1);
        end
      end
    end else if (ctl.shift) begin
      a_nxt = b_r;
      b_nxt = nxt_a;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= 1'b0;
      deb_rem_r  <= '0;
      deb_run_r  <= 1'b0;
      pf_r       <= 1'b0;
      long_rem_r <= '0;
      long_run_r <= 1'b0;
      a_r        <= '0;
      b_r        <= '0;
    end else begin
      prev_r     <= prev_nxt;
      deb_rem_r  <= deb_rem_nxt;
      deb_run_r  <= deb_run_nxt;
      pf_r       <= pf_nxt;
      long_rem_r <= long_rem_nxt;
      long_run_r <= long_run_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
    end
  end

  assign slot_a = a_r;
  assign slot_b = b_r;

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for button_debounce_long_press_unit
// Ticks of raw pin levels go in through the input stream. A behavioral
// model of the debounce and long-press countdowns predicts the press,
// release and long-press events of every accepted tick. Each event request
// on the output stream is checked field by field in order. Register
// settings change between phases while the unit is idle. Both stream sides
// idle at random, and one long output stall fills the unit up.
// ---------------------------------------------------------------------------
module tb_top;
  import bdlp_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int IDLE_PCT      = 10;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    ev_kind_t         kind;
    logic             last;
  } btn_event_t;

  // dut ports
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [LEVEL_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_DEBOUNCE;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // model of the register settings
  logic [TICKS_W-1:0] deb_len  = 16'd20;
  logic [TICKS_W-1:0] long_len = 16'd1000;
  logic [LEVEL_W-1:0] pol_mask = 16'hFFFF;
  logic [COUNT_W-1:0] n_used   = '0;

  // model of the per-button state
  logic               prev_lvl [NUM_BUTTONS];
  logic [TICKS_W-1:0] deb_rem  [NUM_BUTTONS];
  logic               deb_on   [NUM_BUTTONS];
  logic               pressed  [NUM_BUTTONS];
  logic [TICKS_W-1:0] long_rem [NUM_BUTTONS];
  logic               long_on  [NUM_BUTTONS];

  logic [LEVEL_W-1:0] tick_q  [$];
  btn_event_t         event_q [$];

  logic [LEVEL_W-1:0] pin_state = '0;
  logic               in_fire   = 1'b0;
  logic               steady    = 1'b0;
  int                 hold_asked = 0;
  int                 hold_done  = 0;
  int                 hold_left  = 0;
  int                 ticks_queued = 0;
  int                 ticks_taken  = 0;
  int                 events_seen  = 0;
  int                 long_seen    = 0;
  int                 phases_run   = 0;
  int                 idle_cycles  = 0;
  int                 mismatches   = 0;

  button_debounce_long_press_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      prev_lvl[b] = 1'b0;
      deb_rem[b]  = '0;
      deb_on[b]   = 1'b0;
      pressed[b]  = 1'b0;
      long_rem[b] = '0;
      long_on[b]  = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // advance all scanned buttons by one tick and queue the events raised
  function automatic void predict_tick(input logic [LEVEL_W-1:0] levels);
    btn_event_t tick_ev [$];
    btn_event_t ev;
    int         cnt;
    logic       lvl;
    logic       is_down;
    cnt = (n_used > NUM_BUTTONS) ? NUM_BUTTONS : int'(n_used);
    for (int b = 0; b < cnt; b++) begin
      lvl = levels[b];
      // long-press countdown comes first
      if (long_on[b]) begin
        if (long_rem[b] <= 1) begin
          long_rem[b] = '0;
          long_on[b]  = 1'b0;
          if (pressed[b]) begin
            ev.idx  = b[IDX_W-1:0];
            ev.kind = EV_LONG;
            ev.last = 1'b0;
            tick_ev.push_back(ev);
          end
        end else begin
          long_rem[b] = long_rem[b] - 1'b1;
        end
      end
      // any edge restarts the debounce countdown
      if (lvl != prev_lvl[b]) begin
        prev_lvl[b] = lvl;
        deb_rem[b]  = deb_len;
        deb_on[b]   = 1'b1;
      end else if (deb_on[b]) begin
        if (deb_rem[b] <= 1) begin
          deb_rem[b] = '0;
          deb_on[b]  = 1'b0;
          is_down    = pol_mask[b] ? !lvl : lvl;
          if (is_down && !pressed[b]) begin
            pressed[b]  = 1'b1;
            ev.idx      = b[IDX_W-1:0];
            ev.kind     = EV_PRESS;
            ev.last     = 1'b0;
            tick_ev.push_back(ev);
            long_rem[b] = long_len;
            long_on[b]  = 1'b1;
          end else if (!is_down && pressed[b]) begin
            pressed[b]  = 1'b0;
            long_on[b]  = 1'b0;
            long_rem[b] = '0;
            ev.idx      = b[IDX_W-1:0];
            ev.kind     = EV_RELEASE;
            ev.last     = 1'b0;
            tick_ev.push_back(ev);
          end
        end else begin
          deb_rem[b] = deb_rem[b] - 1'b1;
        end
      end
    end
    for (int k = 0; k < tick_ev.size(); k++) begin
      ev      = tick_ev[k];
      ev.last = (k == tick_ev.size() - 1);
      event_q.push_back(ev);
    end
  endfunction

  // monitor: sample both streams at the rising edge
  always @(posedge clk) begin
    btn_event_t want;
    in_fire = in_tvalid && in_tready;
    if (in_fire) begin
      predict_tick(in_tdata);
      ticks_taken++;
    end
    if (out_tvalid && out_tready) begin
      events_seen++;
      if (out_tdata[5:4] == EV_LONG) long_seen++;
      if (event_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event, button %0d kind %0d last %0b",
                                  out_tdata[3:0], out_tdata[5:4], out_tlast));
      end else begin
        want = event_q.pop_front();
        if (out_tdata[3:0] != want.idx)
          report_mismatch($sformatf("button_index %0d, expected %0d",
                                    out_tdata[3:0], want.idx));
        if (out_tdata[5:4] != want.kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d on button %0d",
                                    out_tdata[5:4], want.kind, want.idx));
        if (out_tlast != want.last)
          report_mismatch($sformatf("last_event %0b, expected %0b on button %0d",
                                    out_tlast, want.last, want.idx));
        if (out_tdata[7:6] != 2'b00)
          report_mismatch($sformatf("pad bits %0b, expected 0", out_tdata[7:6]));
      end
    end
    if (in_fire || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // driver: offer queued ticks at the falling edge
  always @(negedge clk) begin
    logic               nv;
    logic [LEVEL_W-1:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (tick_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nv = 1'b1;
        nd = tick_q.pop_front();
      end else begin
        nv = 1'b0;
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no request moving
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // wait until every tick is taken and every event has come out
  task automatic wait_idle();
    while (ticks_taken != ticks_queued || event_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(input logic [TICKS_W-1:0] deb, input logic [TICKS_W-1:0] lng,
                            input logic [LEVEL_W-1:0] mask, input logic [COUNT_W-1:0] used);
    wait_idle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_MASK, mask);
    write_reg(REG_IN_USE, CFG_W'(used));
    @(negedge clk);
    cfg_we   <= 1'b0;
    deb_len  = deb;
    long_len = lng;
    pol_mask = mask;
    n_used   = used;
    phases_run++;
  endtask

  task automatic queue_tick(input logic [LEVEL_W-1:0] lv);
    tick_q.push_back(lv);
    ticks_queued++;
  endtask

  // random levels: each pin toggles with the given chance per tick
  task automatic run_phase(input logic [TICKS_W-1:0] deb, input logic [TICKS_W-1:0] lng,
                           input logic [LEVEL_W-1:0] mask, input logic [COUNT_W-1:0] used,
                           input int n_ticks, input int flip_pct);
    set_config(deb, lng, mask, used);
    for (int t = 0; t < n_ticks; t++) begin
      for (int b = 0; b < LEVEL_W; b++)
        if ($urandom_range(0, 99) < flip_pct) pin_state[b] = ~pin_state[b];
      queue_tick(pin_state);
    end
  endtask

  initial begin
    logic [LEVEL_W-1:0] directed [$];
    directed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
                 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'hAAAA, 16'h5555,
                 16'hAAAA, 16'h0000, 16'h0000, 16'h0000};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: no button scanned, nothing may come out
    for (int t = 0; t < 5; t++) queue_tick($urandom);

    // directed: press, release, long press, restart at expiry, both polarities
    set_config(16'd2, 16'd3, 16'h00FF, 5'd16);
    foreach (directed[k]) queue_tick(directed[k]);
    pin_state = 16'h0000;

    // zero lengths act as one, count above sixteen is clamped
    run_phase(16'd0, 16'd0, 16'hA5A5, 5'd31, 30, 20);
    // long press far away, never fires
    run_phase(16'd1, 16'hFFFF, 16'($urandom), 5'd16, 30, 15);

    // mostly clean button activity with short countdowns
    for (int p = 0; p < 6; p++) begin
      steady = (p == 1);
      if (p == 3) hold_asked++;
      run_phase(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)), 16'($urandom),
                (p == 4) ? 5'd16 : 5'($urandom_range(1, 16)), 33, 8);
    end
    steady = 1'b0;

    // largest countdowns with active-high polarity on all pins
    run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 5'd16, 15, 20);
    // a single button in use
    run_phase(16'd3, 16'd5, 16'hFFFF, 5'd1, 20, 10);
    // heavy bouncing
    run_phase(16'd1, 16'd2, 16'($urandom), 5'd16, 30, 50);
    // nothing scanned, state must hold
    run_phase(16'd2, 16'd4, 16'h1234, 5'd0, 10, 30);

    wait_idle();
    $display("covered %0d ticks over %0d register settings", ticks_taken, phases_run);
    $display("checked %0d events, %0d of them long presses", events_seen, long_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bdlp_pkg.sv
rtl/bdlp_cell.sv
rtl/button_debounce_long_press_unit.sv
tb/tb_top.sv
